// ===== hdl/ofl_pkg.sv =====
package ofl_pkg;

	// defaults for the top level parameters
	localparam int DEF_NUM_BLOCKS = 1024;
	localparam int DEF_NUM_OWNERS = 3;
	localparam int DEF_MAX_GRANT  = 64;

	// field widths fixed by the stream format
	localparam int FUNC_W  = 2;
	localparam int OWNER_W = 2;
	localparam int INDEX_W = 10;
	localparam int COUNT_W = 7;
	localparam int STAT_W  = 3;
	localparam int OBLK_W  = 11;

	// tdata widths, padded to whole bytes
	localparam int IN_TW  = 24;
	localparam int OUT_TW = 24;

	typedef enum logic [FUNC_W-1:0] {
		FN_ALLOC = 2'd0,
		FN_CLAIM = 2'd1,
		FN_FREE  = 2'd2,
		FN_RSVD  = 2'd3
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		STS_OK       = 3'd0,
		STS_NONE     = 3'd1,
		STS_OWNER    = 3'd2,
		STS_NOT_FREE = 3'd3,
		STS_MISMATCH = 3'd4
	} status_t;

	// one result word from the sequencer to the output register
	typedef struct packed {
		logic                last;
		logic [OBLK_W-1:0]   owner_blocks;
		status_t             status;
		logic [INDEX_W-1:0]  block;
	} res_t;

endpackage

// ===== hdl/ofl_ram.sv =====
module ofl_ram #(
	parameter int DW    = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/ofl_ctrl.sv =====
module ofl_ctrl #(
	parameter int NUM_BLOCKS = 1024,
	parameter int NUM_OWNERS = 3,
	parameter int MAX_GRANT  = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ofl_pkg::FUNC_W-1:0]    in_func,
	input  logic [ofl_pkg::OWNER_W-1:0]   in_owner,
	input  logic [ofl_pkg::INDEX_W-1:0]   in_index,
	input  logic [ofl_pkg::COUNT_W-1:0]   in_count,
	output logic                          res_valid,
	input  logic                          res_ready,
	output ofl_pkg::res_t                 res
);

	import ofl_pkg::*;

	localparam int IW = $clog2(NUM_BLOCKS);
	localparam int CW = $clog2(NUM_BLOCKS + 1);
	localparam int MW = (CW > COUNT_W) ? CW : COUNT_W;
	localparam int XW = (CW > INDEX_W) ? CW : INDEX_W + 1;
	localparam logic [IW-1:0] LAST_IX = IW'(NUM_BLOCKS - 1);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	state_t              state_q;
	logic [IW-1:0]       clr_q;
	func_t               func_q;
	logic [OWNER_W-1:0]  own_q;
	logic [INDEX_W-1:0]  idx_q;
	logic [COUNT_W-1:0]  rem_q;
	logic [IW-1:0]       head_q;
	logic [IW-1:0]       tail_q;
	logic [CW-1:0]       ft_q;
	logic [CW-1:0]       cnt_q [4];

	// memory ports
	logic          nx_we, pv_we, tg_we;
	logic [IW-1:0] nx_wa, pv_wa, tg_wa;
	logic [IW-1:0] nx_wd, pv_wd;
	logic [OWNER_W-1:0] tg_wd;
	logic          nx_re, pv_re, tg_re;
	logic [IW-1:0] nx_ra, pv_ra, tg_ra;
	logic [IW-1:0] nx_rd, pv_rd;
	logic [OWNER_W-1:0] tg_rd;

	ofl_ram #(.DW(IW), .DEPTH(NUM_BLOCKS)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
		.re(nx_re), .raddr(nx_ra), .rdata(nx_rd)
	);

	ofl_ram #(.DW(IW), .DEPTH(NUM_BLOCKS)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
		.re(pv_re), .raddr(pv_ra), .rdata(pv_rd)
	);

	ofl_ram #(.DW(OWNER_W), .DEPTH(NUM_BLOCKS)) u_tag (
		.clk(clk), .we(tg_we), .waddr(tg_wa), .wdata(tg_wd),
		.re(tg_re), .raddr(tg_ra), .rdata(tg_rd)
	);

	logic                accept, fire;
	logic [COUNT_W-1:0]  want_sat, rem_init;
	logic [IW-1:0]       in_ia, ia;
	logic                legal, in_pool, alloc_go, claim_ok, free_ok;
	logic [CW-1:0]       cur;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign res_valid = (state_q == ST_EXEC);
	assign fire      = res_valid && res_ready;

	assign want_sat = (in_count > COUNT_W'(MAX_GRANT)) ? COUNT_W'(MAX_GRANT) : in_count;
	assign rem_init = (MW'(want_sat) < MW'(ft_q)) ? want_sat : COUNT_W'(ft_q);
	assign in_ia    = IW'(in_index);
	assign ia       = IW'(idx_q);

	assign legal    = (own_q != '0) && ({1'b0, own_q} < 3'(NUM_OWNERS));
	assign in_pool  = XW'(idx_q) < XW'(NUM_BLOCKS);
	assign cur      = cnt_q[own_q];
	assign alloc_go = legal && (func_q == FN_ALLOC) && (rem_q != '0);
	assign claim_ok = legal && (func_q == FN_CLAIM) && in_pool && (tg_rd == '0)
		&& (ft_q != '0);
	assign free_ok  = legal && (func_q == FN_FREE) && in_pool && (tg_rd == own_q);

	// result word
	always_comb begin
		res.block        = idx_q;
		res.status       = STS_OK;
		res.owner_blocks = OBLK_W'(cur);
		res.last         = 1'b1;
		if (!legal || func_q == FN_RSVD) begin
			res.block        = (func_q == FN_ALLOC) ? '0 : idx_q;
			res.status       = STS_OWNER;
			res.owner_blocks = '0;
		end else begin
			case (func_q)
				FN_ALLOC: begin
					if (rem_q == '0) begin
						res.block  = '0;
						res.status = STS_NONE;
					end else begin
						res.block        = INDEX_W'(head_q);
						res.owner_blocks = OBLK_W'(cur + 1'b1);
						res.last         = (rem_q == COUNT_W'(1));
					end
				end
				FN_CLAIM: begin
					if (claim_ok) begin
						res.owner_blocks = OBLK_W'(cur + 1'b1);
					end else begin
						res.status = STS_NOT_FREE;
					end
				end
				FN_FREE: begin
					if (free_ok) begin
						res.owner_blocks = (cur != '0) ? OBLK_W'(cur - 1'b1) : OBLK_W'(cur);
					end else begin
						res.status = STS_MISMATCH;
					end
				end
				default: begin
					res.status = STS_OWNER;
				end
			endcase
		end
	end

	// memory access
	always_comb begin
		nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
		pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
		tg_we = 1'b0; tg_wa = '0; tg_wd = '0;
		nx_re = 1'b0; pv_re = 1'b0; tg_re = 1'b0;
		nx_ra = (func_t'(in_func) == FN_ALLOC) ? head_q : in_ia;
		pv_ra = in_ia;
		tg_ra = in_ia;
		case (state_q)
			ST_CLEAR: begin
				nx_we = 1'b1; nx_wa = clr_q;
				nx_wd = (clr_q == LAST_IX) ? '0 : clr_q + 1'b1;
				pv_we = 1'b1; pv_wa = clr_q;
				pv_wd = (clr_q == '0) ? LAST_IX : clr_q - 1'b1;
				tg_we = 1'b1; tg_wa = clr_q; tg_wd = '0;
			end
			ST_IDLE: begin
				nx_re = accept;
				pv_re = accept;
				tg_re = accept;
			end
			ST_EXEC: begin
				if (fire && alloc_go) begin
					tg_we = 1'b1; tg_wa = head_q; tg_wd = own_q;
					// follow the chain: next head's successor
					nx_re = 1'b1; nx_ra = nx_rd;
				end
				if (fire && claim_ok) begin
					tg_we = 1'b1; tg_wa = ia; tg_wd = own_q;
					nx_we = (ia != head_q); nx_wa = pv_rd; nx_wd = nx_rd;
					pv_we = (ia != tail_q); pv_wa = nx_rd; pv_wd = pv_rd;
				end
				if (fire && free_ok) begin
					tg_we = 1'b1; tg_wa = ia; tg_wd = '0;
					nx_we = (ft_q != '0); nx_wa = tail_q; nx_wd = ia;
					pv_we = (ft_q != '0); pv_wa = ia; pv_wd = tail_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			head_q  <= '0;
			tail_q  <= LAST_IX;
			ft_q    <= CW'(NUM_BLOCKS);
			rem_q   <= '0;
			for (int i = 0; i < 4; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_IX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						rem_q   <= rem_init;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (fire) begin
						if (alloc_go) begin
							ft_q         <= ft_q - 1'b1;
							cnt_q[own_q] <= cur + 1'b1;
							rem_q        <= rem_q - 1'b1;
							if (ft_q != CW'(1)) begin
								head_q <= nx_rd;
							end
							if (rem_q == COUNT_W'(1)) begin
								state_q <= ST_IDLE;
							end
						end else begin
							state_q <= ST_IDLE;
						end
						if (claim_ok) begin
							ft_q         <= ft_q - 1'b1;
							cnt_q[own_q] <= cur + 1'b1;
							if (ia == head_q) begin
								head_q <= nx_rd;
							end
							if (ia == tail_q) begin
								tail_q <= pv_rd;
							end
						end
						if (free_ok) begin
							ft_q   <= ft_q + 1'b1;
							tail_q <= ia;
							if (ft_q == '0) begin
								head_q <= ia;
							end
							if (cur != '0) begin
								cnt_q[own_q] <= cur - 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item fields, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func_t'(in_func);
			own_q  <= in_owner;
			idx_q  <= in_index;
		end
	end

	a_ft_range: assert property (@(posedge clk) disable iff (!arst_n)
		ft_q <= CW'(NUM_BLOCKS))
		else $error("free count beyond pool size");

	a_ends_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(XW'(head_q) < XW'(NUM_BLOCKS)) && (XW'(tail_q) < XW'(NUM_BLOCKS)))
		else $error("queue end outside pool");

	a_grant_takes_one: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && alloc_go) |=> (ft_q == $past(ft_q) - CW'(1)))
		else $error("grant did not take one block from the queue");

	a_free_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && free_ok) |-> (ft_q != CW'(NUM_BLOCKS)))
		else $error("owned block found while queue is full");

endmodule

// ===== hdl/ofl_obuf.sv =====
module ofl_obuf (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          res_valid,
	output logic                          res_ready,
	input  ofl_pkg::res_t                 res,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ofl_pkg::OUT_TW-1:0]    out_data,
	output logic                          out_last
);

	import ofl_pkg::*;

	res_t word_q;
	logic valid_q;

	assign res_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = OUT_TW'({word_q.owner_blocks, word_q.status, word_q.block});
	assign out_last  = word_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			word_q <= res;
		end
	end

endmodule

// ===== hdl/owned_block_free_list.sv =====
// claim, free or error: one result word, formed in ST_EXEC and passed to m_axis through the output register
// allocate: one grant word per cycle while the output register can take it
// input words are taken only in ST_IDLE, after every word of the previous one is handed on;
//   the link memories are read as a word is taken and written as each result word is handed on
// reset (arst_n low, asynchronous) starts a clearing pass over all NUM_BLOCKS entries that rebuilds
//   the links and owner tags; no input word is taken until it finishes
module owned_block_free_list #(
	parameter int NUM_BLOCKS = ofl_pkg::DEF_NUM_BLOCKS,
	parameter int NUM_OWNERS = ofl_pkg::DEF_NUM_OWNERS,
	parameter int MAX_GRANT  = ofl_pkg::DEF_MAX_GRANT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// func[1:0], owner[3:2], block_index[13:4], block_count[20:14], zero pad
	input  logic [ofl_pkg::IN_TW-1:0]   s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// granted_block[9:0], status[12:10], owner_blocks[23:13]
	output logic [ofl_pkg::OUT_TW-1:0]  m_axis_tdata,
	output logic                        m_axis_tlast
);

	import ofl_pkg::*;

	res_t res;
	logic res_valid, res_ready;

	// sequencer: holds queue ends, free count and owner counts, drives the
	// next/prev link and owner tag memories
	ofl_ctrl #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.NUM_OWNERS(NUM_OWNERS),
		.MAX_GRANT (MAX_GRANT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_func   (s_axis_tdata[1:0]),
		.in_owner  (s_axis_tdata[3:2]),
		.in_index  (s_axis_tdata[13:4]),
		.in_count  (s_axis_tdata[20:14]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register; the sequencer stalls while a word waits in it and m_axis_tready is low
	ofl_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import ofl_pkg::*;

	localparam int BLOCKS = DEF_NUM_BLOCKS;
	localparam int OWNERS = DEF_NUM_OWNERS;
	localparam int GRANT  = DEF_MAX_GRANT;

	// one request word as the sender sees it
	typedef struct {
		func_t              fn;
		logic [OWNER_W-1:0] own;
		logic [INDEX_W-1:0] idx;
		logic [COUNT_W-1:0] cnt;
	} req_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	// func[1:0], owner[3:2], block_index[13:4], block_count[20:14], zero pad
	logic [IN_TW-1:0]  s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	// granted_block[9:0], status[12:10], owner_blocks[23:13]
	logic [OUT_TW-1:0] m_axis_tdata;
	logic              m_axis_tlast;

	owned_block_free_list dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// requests waiting for the driver, words owed by the block
	req_t pending_reqs[$];
	res_t due_words[$];

	// pool as the testbench believes it to be
	logic [INDEX_W-1:0] link_nxt[BLOCKS];
	logic [INDEX_W-1:0] link_prv[BLOCKS];
	logic [INDEX_W-1:0] q_head;
	logic [INDEX_W-1:0] q_tail;
	logic [OBLK_W-1:0]  n_free;
	logic [OWNER_W-1:0] blk_owner[BLOCKS];
	logic [OBLK_W-1:0]  held_by[4];

	int   send_gap_pct = 0;
	int   sink_stall_pct = 0;
	int   mismatches = 0;
	logic took_req = 1'b0;

	initial begin
		forever #4 clk = ~clk;
	end

	// hard stop in case the block hangs or drops words
	initial begin
		#4_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic note_mismatch(input string what, input int got, input int want);
		if (mismatches < 40)
			$display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic owe(input logic [INDEX_W-1:0] b, input status_t st,
			input logic [OBLK_W-1:0] held, input logic lst);
		res_t w;
		w.block        = b;
		w.status       = st;
		w.owner_blocks = held;
		w.last         = lst;
		due_words.insert(due_words.size(), w);
	endtask

	// state after the clearing pass that follows reset
	task automatic clear_pool();
		for (int i = 0; i < BLOCKS; i++) begin
			link_nxt[i]  = INDEX_W'(i + 1);
			link_prv[i]  = INDEX_W'(i + BLOCKS - 1);
			blk_owner[i] = '0;
		end
		q_head = '0;
		q_tail = INDEX_W'(BLOCKS - 1);
		n_free = OBLK_W'(BLOCKS);
		for (int i = 0; i < 4; i++)
			held_by[i] = '0;
	endtask

	// update the pool for one accepted request and queue the words it owes
	task automatic book_request(input logic [IN_TW-1:0] word);
		func_t              fn;
		logic [OWNER_W-1:0] own;
		logic [INDEX_W-1:0] idx;
		int                 want;
		int                 n;
		logic [INDEX_W-1:0] b;
		logic [INDEX_W-1:0] nx;
		logic [INDEX_W-1:0] pv;
		fn   = func_t'(word[1:0]);
		own  = word[3:2];
		idx  = word[13:4];
		want = int'(word[20:14]);
		if (fn == FN_RSVD || own == 0 || own >= OWNERS) begin
			// bad owner or unused op: echo the index unless allocating
			owe(fn == FN_ALLOC ? '0 : idx, STS_OWNER, '0, 1'b1);
			return;
		end
		case (fn)
			FN_ALLOC: begin
				if (want > GRANT)
					want = GRANT;
				n = (want < n_free) ? want : int'(n_free);
				if (n == 0) begin
					owe('0, STS_NONE, held_by[own], 1'b1);
				end else begin
					// walk from the head, one word per block
					for (int k = 0; k < n; k++) begin
						b = q_head;
						blk_owner[b] = own;
						n_free--;
						if (n_free != 0)
							q_head = link_nxt[b];
						held_by[own]++;
						owe(b, STS_OK, held_by[own], k == n - 1);
					end
				end
			end
			FN_CLAIM: begin
				if (blk_owner[idx] != 0 || n_free == 0) begin
					owe(idx, STS_NOT_FREE, held_by[own], 1'b1);
				end else begin
					// unlink from wherever it sits in the queue
					nx = link_nxt[idx];
					pv = link_prv[idx];
					if (idx != q_head)
						link_nxt[pv] = nx;
					else
						q_head = nx;
					if (idx != q_tail)
						link_prv[nx] = pv;
					else
						q_tail = pv;
					n_free--;
					blk_owner[idx] = own;
					held_by[own]++;
					owe(idx, STS_OK, held_by[own], 1'b1);
				end
			end
			default: begin
				if (blk_owner[idx] != own) begin
					owe(idx, STS_MISMATCH, held_by[own], 1'b1);
				end else begin
					// append at the tail, or restart an empty queue
					blk_owner[idx] = '0;
					if (n_free == 0) begin
						q_head = idx;
					end else begin
						link_nxt[q_tail] = idx;
						link_prv[idx]    = q_tail;
					end
					q_tail = idx;
					n_free++;
					if (held_by[own] != 0)
						held_by[own]--;
					owe(idx, STS_OK, held_by[own], 1'b1);
				end
			end
		endcase
	endtask

	// sample both handshakes at the rising edge; predict before checking
	always @(posedge clk) begin : watch
		res_t w;
		if (arst_n) begin
			took_req <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready)
				book_request(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_words.size() == 0) begin
					note_mismatch("word with nothing due", int'(m_axis_tdata[9:0]), 0);
				end else begin
					w = due_words[0];
					due_words.delete(0);
					if (m_axis_tdata[9:0] != w.block)
						note_mismatch("granted block", int'(m_axis_tdata[9:0]),
							int'(w.block));
					if (m_axis_tdata[12:10] != w.status)
						note_mismatch("status", int'(m_axis_tdata[12:10]), int'(w.status));
					if (m_axis_tdata[23:13] != w.owner_blocks)
						note_mismatch("owner blocks", int'(m_axis_tdata[23:13]),
							int'(w.owner_blocks));
					if (m_axis_tlast != w.last)
						note_mismatch("last flag", int'(m_axis_tlast), int'(w.last));
				end
			end
		end
	end

	// drive at the falling edge: hold an unaccepted word, else maybe present the next
	always @(negedge clk) begin : drive
		req_t r;
		if (arst_n) begin
			if (!(s_axis_tvalid && !took_req)) begin
				if (pending_reqs.size() != 0 && $urandom_range(99, 0) >= send_gap_pct) begin
					r = pending_reqs[0];
					pending_reqs.delete(0);
					s_axis_tdata  <= {3'b000, r.cnt, r.idx, r.own, r.fn};
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			m_axis_tready <= $urandom_range(99, 0) >= sink_stall_pct;
		end
	end

	task automatic push_req(input func_t fn, input int own, input int idx, input int cnt);
		req_t r;
		r.fn  = fn;
		r.own = OWNER_W'(own);
		r.idx = INDEX_W'(idx);
		r.cnt = COUNT_W'(cnt);
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	// some block carrying the given tag, from a random starting point
	function automatic int find_tagged(input int tag);
		int start;
		start = $urandom_range(BLOCKS - 1, 0);
		for (int i = 0; i < BLOCKS; i++)
			if (blk_owner[(start + i) % BLOCKS] == tag)
				return (start + i) % BLOCKS;
		return -1;
	endfunction

	// keep the driver fed while staying close to the current pool state
	task automatic top_up();
		while (pending_reqs.size() > 1)
			@(posedge clk);
	endtask

	// wait until nothing is queued, in flight or owed
	task automatic settle();
		while (pending_reqs.size() != 0 || s_axis_tvalid || due_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic add_random_item();
		int pick;
		int own;
		int idx;
		int cnt;
		pick = $urandom_range(99, 0);
		own  = $urandom_range(OWNERS - 1, 1);
		if (pick < 30) begin
			// allocate, mostly small, now and then saturating
			pick = $urandom_range(99, 0);
			if (pick < 80)
				cnt = $urandom_range(8, 1);
			else if (pick < 93)
				cnt = $urandom_range(64, 9);
			else if (pick < 97)
				cnt = $urandom_range(127, 65);
			else
				cnt = 0;
			push_req(FN_ALLOC, own, $urandom_range(BLOCKS - 1, 0), cnt);
		end else if (pick < 55) begin
			idx = find_tagged(0);
			if (idx < 0)
				idx = $urandom_range(BLOCKS - 1, 0);
			push_req(FN_CLAIM, own, idx, $urandom_range(127, 0));
		end else if (pick < 85) begin
			idx = find_tagged(own);
			if (idx < 0)
				idx = $urandom_range(BLOCKS - 1, 0);
			push_req(FN_FREE, own, idx, $urandom_range(127, 0));
		end else begin
			// malformed requests and requests on random blocks
			case ($urandom_range(4, 0))
				0: push_req(func_t'($urandom_range(3, 0)), 0,
					$urandom_range(BLOCKS - 1, 0), $urandom_range(127, 0));
				1: push_req(func_t'($urandom_range(3, 0)), 3,
					$urandom_range(BLOCKS - 1, 0), $urandom_range(127, 0));
				2: push_req(FN_RSVD, own, $urandom_range(BLOCKS - 1, 0),
					$urandom_range(127, 0));
				3: push_req(FN_CLAIM, own, $urandom_range(BLOCKS - 1, 0),
					$urandom_range(127, 0));
				default: push_req(FN_FREE, $urandom_range(3, 0),
					$urandom_range(BLOCKS - 1, 0), $urandom_range(127, 0));
			endcase
		end
	endtask

	initial begin
		int idx;
		clear_pool();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// sender idles now and then, receiver mostly stalls
		send_gap_pct   = 12;
		sink_stall_pct = 73;

		// directed: field extremes, every op, every error path
		push_req(FN_ALLOC, 1, 0, 0);        // nothing wanted
		push_req(FN_ALLOC, 1, 0, 1);
		push_req(FN_ALLOC, 2, 1023, 127);   // saturates at the grant limit
		push_req(FN_ALLOC, 1, 0, 64);
		push_req(FN_CLAIM, 2, 1023, 0);     // tail of the queue
		push_req(FN_CLAIM, 1, 129, 0);      // head of the queue
		push_req(FN_CLAIM, 2, 500, 0);      // middle of the queue
		push_req(FN_CLAIM, 1, 500, 0);      // no longer free
		push_req(FN_CLAIM, 1, 0, 0);        // held by its owner
		push_req(FN_FREE, 2, 0, 0);         // held by someone else
		push_req(FN_FREE, 1, 0, 0);
		push_req(FN_FREE, 1, 0, 0);         // already free
		push_req(FN_FREE, 2, 1023, 127);
		push_req(FN_ALLOC, 0, 0, 5);        // free owner asking
		push_req(FN_CLAIM, 3, 1000, 0);     // owner out of range
		push_req(FN_FREE, 0, 682, 85);
		push_req(FN_RSVD, 1, 341, 42);      // unused op
		push_req(FN_RSVD, 0, 1023, 127);
		push_req(FN_ALLOC, 3, 682, 127);
		push_req(FN_CLAIM, 2, 0, 0);
		push_req(FN_FREE, 2, 1023, 0);
		push_req(FN_CLAIM, 1, 1023, 0);

		for (int i = 0; i < 85; i++) begin
			top_up();
			add_random_item();
		end

		// hold off until the block has drained, then swap the idling
		settle();
		send_gap_pct   = 73;
		sink_stall_pct = 12;
		for (int i = 0; i < 85; i++) begin
			top_up();
			add_random_item();
		end

		settle();
		send_gap_pct   = 0;
		sink_stall_pct = 0;
		for (int i = 0; i < 85; i++) begin
			top_up();
			add_random_item();
		end

		// run the pool dry, hit the empty queue, then refill from empty
		settle();
		for (int i = 0; i <= n_free / GRANT; i++)
			push_req(FN_ALLOC, 1 + i % 2, 0, 127);
		push_req(FN_ALLOC, 1, 0, 3);
		push_req(FN_CLAIM, 2, $urandom_range(BLOCKS - 1, 0), 0);
		settle();
		for (int i = 0; i < 24; i++) begin
			top_up();
			idx = find_tagged(1 + i % 2);
			push_req(FN_FREE, 1 + i % 2, idx < 0 ? 0 : idx, 0);
		end
		for (int i = 0; i < 6; i++) begin
			top_up();
			add_random_item();
		end

		settle();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/ofl_pkg.sv
hdl/ofl_ram.sv
hdl/ofl_ctrl.sv
hdl/ofl_obuf.sv
hdl/owned_block_free_list.sv
sim/tb_top.sv
